// File: rtl/mfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mfc_pkg;

    localparam int unsigned POS_W     = 9;
    localparam int unsigned SIZE_W    = POS_W + 1;
    localparam int unsigned ADDR_BYTES = 6;
    localparam int unsigned ADDR_W    = 8 * ADDR_BYTES;

    localparam logic [7:0]       START_CHAR  = 8'h68;
    localparam logic [7:0]       END_CHAR    = 8'h16;
    localparam logic [POS_W-1:0] POS_MAX     = 9'd511;
    localparam logic [POS_W-1:0] OFF_ADDR_LO = 9'd1;
    localparam logic [POS_W-1:0] OFF_ADDR_HI = 9'd6;
    localparam logic [POS_W-1:0] OFF_START2  = 9'd7;
    localparam logic [POS_W-1:0] OFF_CTRL    = 9'd8;
    localparam logic [POS_W-1:0] OFF_LEN     = 9'd9;
    localparam logic [POS_W-1:0] OFF_DATA    = 9'd10;
    localparam logic [SIZE_W-1:0] MIN_FRAME  = 10'd12;

    typedef enum logic {
        KIND_DATA    = 1'b0,
        KIND_VERDICT = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_MALFORMED = 3'd1,
        ST_NO_START  = 3'd2,
        ST_NO_END    = 3'd3,
        ST_BAD_SUM   = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_buffer;
    } beat_t;

    typedef struct packed {
        kind_t             kind;
        logic [7:0]        data_byte;
        logic [7:0]        data_index;
        status_t           status;
        logic [ADDR_W-1:0] address;
        logic [7:0]        control;
        logic [7:0]        length;
    } result_t;

    function automatic logic is_bcd(input logic [7:0] b);
        return (b[7:4] <= 4'd9) && (b[3:0] <= 4'd9);
    endfunction

endpackage

`default_nettype wire

// File: rtl/mfc_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module mfc_in_stage (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [7:0]    s_rx_byte,
    input  wire logic          s_end_of_buffer,
    input  wire logic          advance,
    output logic               beat_valid,
    output mfc_pkg::beat_t     beat
);

    logic           valid_reg;
    mfc_pkg::beat_t beat_reg;

    assign s_ready    = !valid_reg || advance;
    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            beat_reg.rx_byte       <= s_rx_byte;
            beat_reg.end_of_buffer <= s_end_of_buffer;
        end
    end

endmodule

`default_nettype wire

// File: rtl/mfc_frame_core.sv
`timescale 1ns / 1ps
`default_nettype none

module mfc_frame_core (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           step,
    input  wire mfc_pkg::beat_t beat,
    output logic                res_valid,
    output mfc_pkg::result_t    result
);

    logic                       in_frame_reg, in_frame_next;
    logic [mfc_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [mfc_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic                       bcd_ok_reg, bcd_ok_next;
    logic                       start2_ok_reg, start2_ok_next;
    logic [7:0]                 ctrl_reg, ctrl_next;
    logic [7:0]                 len_reg, len_next;
    logic [7:0]                 sum_reg, sum_next;
    logic [7:0]                 prev_reg, prev_next;

    logic                       frame_now;
    logic [mfc_pkg::POS_W-1:0]  off;
    logic [mfc_pkg::POS_W-1:0]  data_off;
    logic [mfc_pkg::SIZE_W-1:0] size;
    logic                       emit;
    logic [7:0]                 b;
    logic                       last;
    mfc_pkg::status_t           status;

    assign b         = beat.rx_byte;
    assign last      = beat.end_of_buffer;
    assign frame_now = in_frame_reg || (b == mfc_pkg::START_CHAR);
    assign off       = in_frame_reg ? pos_reg : '0;
    assign size      = {1'b0, off} + mfc_pkg::SIZE_W'(1);
    assign data_off  = off - mfc_pkg::OFF_DATA;

    // field capture for this byte
    always_comb begin
        addr_next      = addr_reg;
        bcd_ok_next    = bcd_ok_reg;
        start2_ok_next = start2_ok_reg;
        ctrl_next      = ctrl_reg;
        len_next       = len_reg;
        for (int i = 0; i < mfc_pkg::ADDR_BYTES; i++) begin
            if (frame_now && off == mfc_pkg::POS_W'(i + 1)) begin
                addr_next[8*i +: 8] = addr_reg[8*i +: 8] | b;
            end
        end
        if (frame_now && off >= mfc_pkg::OFF_ADDR_LO && off <= mfc_pkg::OFF_ADDR_HI
                && !mfc_pkg::is_bcd(b)) begin
            bcd_ok_next = 1'b0;
        end
        if (frame_now && off == mfc_pkg::OFF_START2) begin
            start2_ok_next = (b == mfc_pkg::START_CHAR);
        end
        if (frame_now && off == mfc_pkg::OFF_CTRL) begin
            ctrl_next = b;
        end
        if (frame_now && off == mfc_pkg::OFF_LEN) begin
            len_next = b;
        end
    end

    assign emit = frame_now && !last && off >= mfc_pkg::OFF_DATA
                  && data_off < {1'b0, len_reg};

    // verdict in priority order
    always_comb begin
        if (!frame_now || size < mfc_pkg::MIN_FRAME) begin
            status = mfc_pkg::ST_MALFORMED;
        end else if (!start2_ok_next) begin
            status = mfc_pkg::ST_NO_START;
        end else if (!bcd_ok_next) begin
            status = mfc_pkg::ST_MALFORMED;
        end else if (size != ({2'b00, len_next} + mfc_pkg::MIN_FRAME)) begin
            status = mfc_pkg::ST_MALFORMED;
        end else if (b != mfc_pkg::END_CHAR) begin
            status = mfc_pkg::ST_NO_END;
        end else if (8'(sum_reg - prev_reg) != prev_reg) begin
            status = mfc_pkg::ST_BAD_SUM;
        end else begin
            status = mfc_pkg::ST_OK;
        end
    end

    always_comb begin
        res_valid = last || emit;
        if (last) begin
            result.kind       = mfc_pkg::KIND_VERDICT;
            result.data_byte  = '0;
            result.data_index = '0;
            result.status     = status;
            result.address    = addr_next;
            result.control    = ctrl_next;
            result.length     = len_next;
        end else begin
            result.kind       = mfc_pkg::KIND_DATA;
            result.data_byte  = b;
            result.data_index = data_off[7:0];
            result.status     = mfc_pkg::ST_OK;
            result.address    = '0;
            result.control    = '0;
            result.length     = '0;
        end
    end

    assign in_frame_next = frame_now;
    assign pos_next      = (off == mfc_pkg::POS_MAX) ? mfc_pkg::POS_MAX
                                                     : off + mfc_pkg::POS_W'(1);
    assign sum_next      = sum_reg + b;
    assign prev_next     = b;

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && last)) begin
            in_frame_reg  <= 1'b0;
            pos_reg       <= '0;
            addr_reg      <= '0;
            bcd_ok_reg    <= 1'b1;
            start2_ok_reg <= 1'b0;
            ctrl_reg      <= '0;
            len_reg       <= '0;
            sum_reg       <= '0;
            prev_reg      <= '0;
        end else if (step && frame_now) begin
            in_frame_reg  <= in_frame_next;
            pos_reg       <= pos_next;
            addr_reg      <= addr_next;
            bcd_ok_reg    <= bcd_ok_next;
            start2_ok_reg <= start2_ok_next;
            ctrl_reg      <= ctrl_next;
            len_reg       <= len_next;
            sum_reg       <= sum_next;
            prev_reg      <= prev_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/mfc_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module mfc_out_stage (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             advance,
    input  wire logic             res_valid,
    input  wire mfc_pkg::result_t result,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic                  space,
    output mfc_pkg::result_t      m_result
);

    logic             valid_reg;
    mfc_pkg::result_t result_reg;

    assign m_valid  = valid_reg;
    assign m_result = result_reg;
    assign space    = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= res_valid;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            result_reg <= result;
        end
    end

endmodule

`default_nettype wire

// File: rtl/meter_frame_checker_unit.sv
// channel | handshake       | payload ports                                   | carries
// s_      | s_valid s_ready | s_rx_byte s_end_of_buffer                       | buffer bytes
// m_      | m_valid m_ready | m_result_kind to m_data_length, seven fields    | data bytes, verdicts
//
// one byte per cycle if no m_ stall: input register, one pass of header/sum checks, result register
// a byte goes input register -> result register; bytes with no result are dropped
// reset: synchronous active-low aresetn, empties both stages and restarts the start hunt
// a stall at m_ freezes the result; the input register takes one more beat only if it is empty
`timescale 1ns / 1ps
`default_nettype none

module meter_frame_checker_unit (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [7:0]                 s_rx_byte,
    input  wire logic                       s_end_of_buffer,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic                            m_result_kind,
    output logic [7:0]                      m_data_byte,
    output logic [7:0]                      m_data_index,
    output logic [2:0]                      m_frame_status,
    output logic [mfc_pkg::ADDR_W-1:0]      m_meter_address,
    output logic [7:0]                      m_control_code,
    output logic [7:0]                      m_data_length
);

    logic             beat_valid;
    mfc_pkg::beat_t   beat;
    logic             space;
    logic             advance;
    logic             res_valid;
    mfc_pkg::result_t result;
    mfc_pkg::result_t m_result;

    assign advance = beat_valid && space;

    mfc_in_stage u_in_stage (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .s_end_of_buffer (s_end_of_buffer),
        .advance         (advance),
        .beat_valid      (beat_valid),
        .beat            (beat)
    );

    mfc_frame_core u_frame_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .beat      (beat),
        .res_valid (res_valid),
        .result    (result)
    );

    mfc_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .res_valid (res_valid),
        .result    (result),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .space     (space),
        .m_result  (m_result)
    );

    assign m_result_kind   = m_result.kind;
    assign m_data_byte     = m_result.data_byte;
    assign m_data_index    = m_result.data_index;
    assign m_frame_status  = m_result.status;
    assign m_meter_address = m_result.address;
    assign m_control_code  = m_result.control;
    assign m_data_length   = m_result.length;

`ifndef ASSERT_OFF
    a_data_beat_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == mfc_pkg::KIND_DATA |->
            m_frame_status == mfc_pkg::ST_OK && m_meter_address == '0
            && m_control_code == 8'd0 && m_data_length == 8'd0)
        else $error("data beat carries verdict fields");

    a_verdict_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == mfc_pkg::KIND_VERDICT |->
            m_data_byte == 8'd0 && m_data_index == 8'd0)
        else $error("verdict beat carries data fields");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_frame_status <= mfc_pkg::ST_BAD_SUM)
        else $error("frame status out of range");

    a_empty_takes: assert property (@(posedge aclk) disable iff (!aresetn)
        !beat_valid |-> s_ready)
        else $error("empty input register refuses a beat");
`endif

endmodule

`default_nettype wire
